// File: sv/lssp_pkg.sv
// Shared constants, codes and types for the link-state shortest-path router.
// Used by lssp_table, lssp_path and link_state_shortest_path_router.
package lssp_pkg;

   localparam int NODES  = 16;
   localparam int NODE_W = $clog2(NODES);
   localparam int LINK_W = 2 * NODE_W;
   localparam int LINKS  = NODES * NODES;
   localparam int DIST_W = 16;
   localparam int STEP_W = $clog2(NODES + 1);

   localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

   localparam logic [1:0] KIND_LOCAL = 2'd0;
   localparam logic [1:0] KIND_ADV   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [2:0] REG_OWN_NODE = 3'd0;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_PATH = 4'b0100,
      S_FIN  = 4'b1000
   } top_state_type;

   typedef enum logic [7:0] {
      E_IDLE   = 8'b0000_0001,
      E_INIT   = 8'b0000_0010,
      E_SCAN   = 8'b0000_0100,
      E_SETTLE = 8'b0000_1000,
      E_READ   = 8'b0001_0000,
      E_RELAX  = 8'b0010_0000,
      E_WCHK   = 8'b0100_0000,
      E_STEP   = 8'b1000_0000
   } path_state_type;

   typedef struct packed {
      logic              start;
      logic              build;
      logic [NODE_W-1:0] own;
      logic [NODE_W-1:0] target;
   } path_cmd_type;

   typedef struct packed {
      logic              done;
      logic              hop_valid;
      logic [NODE_W-1:0] next_hop;
   } path_stat_type;

endpackage

// File: sv/lssp_table.sv
// Link-state table: cost and age memories with one valid bit per link.
// Depends on lssp_pkg for sizes.
module lssp_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [lssp_pkg::LINK_W-1:0] wr_addr,
   input  logic [15:0]                 wr_cost,
   input  logic [15:0]                 wr_age,
   input  logic [lssp_pkg::LINK_W-1:0] age_addr,
   output logic [15:0]                 age_rd,
   output logic                        age_known,
   input  logic [lssp_pkg::LINK_W-1:0] cost_addr,
   output logic [15:0]                 cost_rd,
   output logic                        cost_known
);

   logic [15:0]                 cost_mem [lssp_pkg::LINKS];
   logic [15:0]                 age_mem  [lssp_pkg::LINKS];
   logic [lssp_pkg::LINKS-1:0]  known_ff;
   logic                        age_known_ff;
   logic                        cost_known_ff;
   logic [15:0]                 age_rd_ff;
   logic [15:0]                 cost_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cost_mem[wr_addr] <= wr_cost;
         age_mem[wr_addr]  <= wr_age;
      end
      age_rd_ff  <= age_mem[age_addr];
      cost_rd_ff <= cost_mem[cost_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff      <= '0;
         age_known_ff  <= 1'b0;
         cost_known_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            known_ff[wr_addr] <= 1'b1;
         end
         age_known_ff  <= known_ff[age_addr];
         cost_known_ff <= known_ff[cost_addr];
      end
   end

   assign age_rd     = age_rd_ff;
   assign age_known  = age_known_ff;
   assign cost_rd    = cost_rd_ff;
   assign cost_known = cost_known_ff;

endmodule

// File: sv/lssp_path.sv
// Shortest-path engine: Dijkstra over the link table with one shared
// add/compare unit, then a predecessor walk to find the first hop.
// Depends on lssp_pkg; reads costs through lssp_table's second port.
module lssp_path (
   input  logic                        clock,
   input  logic                        reset,
   input  lssp_pkg::path_cmd_type      cmd,
   output lssp_pkg::path_stat_type     stat,
   output logic [lssp_pkg::LINK_W-1:0] cost_addr,
   input  logic [15:0]                 cost_rd,
   input  logic                        cost_known
);

   lssp_pkg::path_state_type state_ff, state_in;

   logic [lssp_pkg::DIST_W-1:0] dist_ff [lssp_pkg::NODES];
   logic [lssp_pkg::NODE_W-1:0] pred_ff [lssp_pkg::NODES];
   logic [lssp_pkg::NODES-1:0]  settled_ff;

   logic [lssp_pkg::NODE_W-1:0] idx_ff, idx_in;
   logic [lssp_pkg::NODE_W-1:0] u_ff, u_in;
   logic                        found_ff, found_in;
   logic [lssp_pkg::DIST_W-1:0] best_ff, best_in;
   logic [lssp_pkg::DIST_W-1:0] du_ff, du_in;
   logic [lssp_pkg::NODE_W-1:0] own_ff, own_in;
   logic [lssp_pkg::NODE_W-1:0] target_ff, target_in;
   logic [lssp_pkg::NODE_W-1:0] cur_ff, cur_in;
   logic [lssp_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic                        hop_valid_ff, hop_valid_in;
   logic                        done_ff, done_in;

   // Shared unit: saturating add and compare against the held distance.
   logic [lssp_pkg::DIST_W:0]   sum_wide;
   logic [lssp_pkg::DIST_W-1:0] sum_sat;
   logic                        relax_hit;
   logic                        scan_hit;

   assign sum_wide  = {1'b0, du_ff} + {1'b0, cost_rd};
   assign sum_sat   = sum_wide[lssp_pkg::DIST_W] ? lssp_pkg::DIST_INF
                                                 : sum_wide[lssp_pkg::DIST_W-1:0];
   assign relax_hit = !settled_ff[idx_ff] && cost_known && (sum_sat < dist_ff[idx_ff]);
   assign scan_hit  = !settled_ff[idx_ff] && (dist_ff[idx_ff] < best_ff);

   assign cost_addr = {u_ff, idx_ff};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      u_in         = u_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      du_in        = du_ff;
      own_in       = own_ff;
      target_in    = target_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      hop_valid_in = hop_valid_ff;
      done_in      = 1'b0;
      case (state_ff)
         lssp_pkg::E_IDLE: begin
            if (cmd.start) begin
               own_in    = cmd.own;
               target_in = cmd.target;
               state_in  = cmd.build ? lssp_pkg::E_INIT : lssp_pkg::E_WCHK;
            end
         end
         lssp_pkg::E_INIT: begin
            idx_in   = '0;
            best_in  = lssp_pkg::DIST_INF;
            found_in = 1'b0;
            state_in = lssp_pkg::E_SCAN;
         end
         lssp_pkg::E_SCAN: begin
            if (scan_hit) begin
               best_in  = dist_ff[idx_ff];
               u_in     = idx_ff;
               found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == lssp_pkg::NODE_W'(lssp_pkg::NODES - 1)) begin
               state_in = lssp_pkg::E_SETTLE;
            end
         end
         lssp_pkg::E_SETTLE: begin
            idx_in = '0;
            du_in  = best_ff;
            state_in = found_ff ? lssp_pkg::E_READ : lssp_pkg::E_WCHK;
         end
         lssp_pkg::E_READ: begin
            state_in = lssp_pkg::E_RELAX;
         end
         lssp_pkg::E_RELAX: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == lssp_pkg::NODE_W'(lssp_pkg::NODES - 1)) begin
               best_in  = lssp_pkg::DIST_INF;
               found_in = 1'b0;
               state_in = lssp_pkg::E_SCAN;
            end else begin
               state_in = lssp_pkg::E_READ;
            end
         end
         lssp_pkg::E_WCHK: begin
            cur_in   = target_ff;
            steps_in = '0;
            if (target_ff == own_ff || dist_ff[target_ff] >= lssp_pkg::DIST_INF) begin
               hop_valid_in = 1'b0;
               done_in      = 1'b1;
               state_in     = lssp_pkg::E_IDLE;
            end else begin
               state_in = lssp_pkg::E_STEP;
            end
         end
         lssp_pkg::E_STEP: begin
            if (pred_ff[cur_ff] == own_ff ||
                steps_ff == lssp_pkg::STEP_W'(lssp_pkg::NODES)) begin
               hop_valid_in = 1'b1;
               done_in      = 1'b1;
               state_in     = lssp_pkg::E_IDLE;
            end else begin
               cur_in   = pred_ff[cur_ff];
               steps_in = steps_ff + 1'b1;
            end
         end
         default: begin
            state_in = lssp_pkg::E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lssp_pkg::E_IDLE;
         done_ff    <= 1'b0;
         settled_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         if (state_ff == lssp_pkg::E_INIT) begin
            settled_ff <= '0;
         end else if (state_ff == lssp_pkg::E_SETTLE && found_ff) begin
            settled_ff[u_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      u_ff         <= u_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      du_ff        <= du_in;
      own_ff       <= own_in;
      target_ff    <= target_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      hop_valid_ff <= hop_valid_in;
      if (state_ff == lssp_pkg::E_INIT) begin
         for (int n = 0; n < lssp_pkg::NODES; n++) begin
            dist_ff[n] <= (lssp_pkg::NODE_W'(n) == own_ff) ? '0 : lssp_pkg::DIST_INF;
            pred_ff[n] <= '0;
         end
      end else if (state_ff == lssp_pkg::E_RELAX && relax_hit) begin
         dist_ff[idx_ff] <= sum_sat;
         pred_ff[idx_ff] <= u_ff;
      end
   end

   assign stat.done      = done_ff;
   assign stat.hop_valid = hop_valid_ff;
   assign stat.next_hop  = hop_valid_ff ? cur_ff : '0;

endmodule

// File: sv/link_state_shortest_path_router.sv
// Link-state router taking one beat at a time; the next beat is accepted once the result is out.
// Changes and advertisements take a table lookup before the result; a query on an
// unchanged table runs only the predecessor walk, and one after
// a table change first runs a path rebuild, paced by the
// single add/compare unit that scans and relaxes one node per step.
// Reset is synchronous: table empty, own_node 0, paths marked for rebuild.
module link_state_shortest_path_router (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // src_node, dst_node, link_cost, adv_age, target_node
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // flood_age, flood_src, flood_dst, flood_cost, next_hop
   output logic [1:0]  rsp_tuser,   // flood_valid, hop_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lssp_pkg::top_state_type state_ff, state_in;

   logic [lssp_pkg::NODE_W-1:0] own_ff;
   logic                        dirty_ff;
   logic [1:0]                  kind_ff;
   logic [lssp_pkg::NODE_W-1:0] src_ff, dst_ff;
   logic [15:0]                 cost_ff, age_ff;

   logic        res_flood_ff, res_flood_in;
   logic [15:0] res_age_ff, res_age_in;
   logic        res_hop_ff, res_hop_in;
   logic [3:0]  res_next_ff, res_next_in;

   logic        out_valid_ff;
   logic [47:0] out_data_ff;
   logic [1:0]  out_user_ff;

   logic        req_beat, csr_wr;
   logic        wr_en;
   logic [15:0] age_rd, cost_rd;
   logic        age_known, cost_known;
   logic [lssp_pkg::LINK_W-1:0] cost_addr;
   logic [15:0] old_age;
   logic        adv_stale;

   lssp_pkg::path_cmd_type  cmd;
   lssp_pkg::path_stat_type stat;

   assign req_tready = (state_ff == lssp_pkg::S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == lssp_pkg::REG_OWN_NODE);
   assign csr_prdata = (csr_paddr == lssp_pkg::REG_OWN_NODE)
                       ? {28'd0, own_ff} : 32'd0;

   assign old_age   = age_known ? age_rd : 16'd0;
   assign adv_stale = age_known && (age_rd >= age_ff);
   assign wr_en     = (state_ff == lssp_pkg::S_LOOK) &&
                      (kind_ff == lssp_pkg::KIND_LOCAL || !adv_stale);

   lssp_table u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    ({src_ff, dst_ff}),
      .wr_cost    (cost_ff),
      .wr_age     ((kind_ff == lssp_pkg::KIND_LOCAL) ? old_age + 16'd1 : age_ff),
      .age_addr   ({req_tdata[3:0], req_tdata[7:4]}),
      .age_rd     (age_rd),
      .age_known  (age_known),
      .cost_addr  (cost_addr),
      .cost_rd    (cost_rd),
      .cost_known (cost_known)
   );

   assign cmd.start  = req_beat && (req_tuser == lssp_pkg::KIND_QUERY);
   assign cmd.build  = dirty_ff;
   assign cmd.own    = own_ff;
   assign cmd.target = req_tdata[43:40];

   lssp_path u_path (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cost_addr  (cost_addr),
      .cost_rd    (cost_rd),
      .cost_known (cost_known)
   );

   always_comb begin
      state_in     = state_ff;
      res_flood_in = res_flood_ff;
      res_age_in   = res_age_ff;
      res_hop_in   = res_hop_ff;
      res_next_in  = res_next_ff;
      case (state_ff)
         lssp_pkg::S_IDLE: begin
            if (req_beat) begin
               res_flood_in = 1'b0;
               res_age_in   = 16'd0;
               res_hop_in   = 1'b0;
               res_next_in  = 4'd0;
               case (req_tuser)
                  lssp_pkg::KIND_LOCAL: state_in = lssp_pkg::S_LOOK;
                  lssp_pkg::KIND_ADV:   state_in = lssp_pkg::S_LOOK;
                  lssp_pkg::KIND_QUERY: state_in = lssp_pkg::S_PATH;
                  default:              state_in = lssp_pkg::S_FIN;
               endcase
            end
         end
         lssp_pkg::S_LOOK: begin
            res_flood_in = wr_en;
            res_age_in   = (kind_ff == lssp_pkg::KIND_LOCAL) ? old_age : age_ff;
            state_in     = lssp_pkg::S_FIN;
         end
         lssp_pkg::S_PATH: begin
            if (stat.done) begin
               res_hop_in  = stat.hop_valid;
               res_next_in = stat.next_hop;
               state_in    = lssp_pkg::S_FIN;
            end
         end
         lssp_pkg::S_FIN: begin
            if (!out_valid_ff || rsp_tready) begin
               state_in = lssp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lssp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lssp_pkg::S_IDLE;
         own_ff       <= '0;
         dirty_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            own_ff   <= csr_pwdata[lssp_pkg::NODE_W-1:0];
            dirty_ff <= 1'b1;
         end else if (wr_en) begin
            dirty_ff <= 1'b1;
         end else if (cmd.start) begin
            dirty_ff <= 1'b0;
         end
         if (state_ff == lssp_pkg::S_FIN && (!out_valid_ff || rsp_tready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_flood_ff <= res_flood_in;
      res_age_ff   <= res_age_in;
      res_hop_ff   <= res_hop_in;
      res_next_ff  <= res_next_in;
      if (req_beat) begin
         kind_ff   <= req_tuser;
         src_ff    <= req_tdata[3:0];
         dst_ff    <= req_tdata[7:4];
         cost_ff   <= req_tdata[23:8];
         age_ff    <= req_tdata[39:24];
      end
      // The flood fields read as zero whenever no advertisement goes out.
      if (state_ff == lssp_pkg::S_FIN && (!out_valid_ff || rsp_tready)) begin
         out_data_ff <= {4'd0, res_next_ff,
                         res_flood_ff ? cost_ff : 16'd0,
                         res_flood_ff ? dst_ff : 4'd0,
                         res_flood_ff ? src_ff : 4'd0,
                         res_flood_ff ? res_age_ff : 16'd0};
         out_user_ff <= {res_hop_ff, res_flood_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// File: sim/tb_top.sv
// Self-checking bench for link_state_shortest_path_router: directed table, then random phases.
// Depends on lssp_pkg and the router RTL. A predictor with its own table checks untyped rows.
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]  user;
      logic [47:0] data;
   } rsp_beat_type;

   typedef struct {
      logic [1:0]   kind;
      logic [3:0]   src;
      logic [3:0]   dst;
      logic [15:0]  cost;
      logic [15:0]  age;
      logic [3:0]   tgt;
      bit           typed;
      rsp_beat_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // src_node, dst_node, link_cost, adv_age, target_node
   logic [1:0]  req_tuser = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // flood_age, flood_src, flood_dst, flood_cost, next_hop
   logic [1:0]  rsp_tuser;        // flood_valid, hop_valid
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   link_state_shortest_path_router DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: a private copy of the link table and route cache.
   logic [3:0]  own_m;
   logic [15:0] link_cost_m [lssp_pkg::LINKS];
   bit          link_seen_m [lssp_pkg::LINKS];
   logic [15:0] link_age_m  [lssp_pkg::LINKS];
   logic [3:0]  route_hop_m [lssp_pkg::NODES];
   bit          route_ok_m  [lssp_pkg::NODES];
   bit          routes_stale;

   rsp_beat_type pending_rsp[$];
   int           fails = 0;
   bit           calm = 0;
   bit           hold_req = 0;
   int           cycles = 0;

   function automatic rsp_beat_type pack_rsp(bit fv, logic [15:0] fage, logic [3:0] fsrc,
                                             logic [3:0] fdst, logic [15:0] fcost,
                                             bit hv, logic [3:0] nh);
      rsp_beat_type b;
      b.user = {hv, fv};
      b.data = {4'b0, nh, fcost, fdst, fsrc, fage};
      return b;
   endfunction

   function automatic void rebuild_routes();
      logic [16:0] path_d [lssp_pkg::NODES];
      int          pred [lssp_pkg::NODES];
      bit          done_n [lssp_pkg::NODES];
      int          u, cur, steps;
      logic [16:0] best, sum;
      for (int i = 0; i < lssp_pkg::NODES; i++) begin
         path_d[i] = 17'(lssp_pkg::DIST_INF);
         pred[i] = 0;
         done_n[i] = 0;
         route_ok_m[i] = 0;
         route_hop_m[i] = 0;
      end
      routes_stale = 0;
      path_d[own_m] = 0;
      for (int r = 0; r < lssp_pkg::NODES; r++) begin
         best = 17'(lssp_pkg::DIST_INF);
         u = lssp_pkg::NODES;
         for (int i = 0; i < lssp_pkg::NODES; i++)
            if (!done_n[i] && path_d[i] < best) begin
               best = path_d[i];
               u = i;
            end
         if (u >= lssp_pkg::NODES) break;
         done_n[u] = 1;
         for (int v = 0; v < lssp_pkg::NODES; v++) begin
            if (done_n[v] || !link_seen_m[u*lssp_pkg::NODES+v]) continue;
            sum = path_d[u] + 17'(link_cost_m[u*lssp_pkg::NODES+v]);
            if (sum > 17'(lssp_pkg::DIST_INF)) sum = 17'(lssp_pkg::DIST_INF);
            if (sum < path_d[v]) begin
               path_d[v] = sum;
               pred[v] = u;
            end
         end
      end
      for (int v = 0; v < lssp_pkg::NODES; v++) begin
         if (v == own_m || path_d[v] >= 17'(lssp_pkg::DIST_INF)) continue;
         cur = v;
         steps = 0;
         while (pred[cur] != own_m && steps < lssp_pkg::NODES) begin
            cur = pred[cur];
            steps++;
         end
         route_hop_m[v] = 4'(cur);
         route_ok_m[v] = 1;
      end
   endfunction

   function automatic rsp_beat_type predict_router(stim_row_type s);
      int k;
      logic [15:0] fage;
      k = s.src * lssp_pkg::NODES + s.dst;
      if (s.kind == lssp_pkg::KIND_LOCAL) begin
         fage = link_age_m[k];
         link_cost_m[k] = s.cost;
         link_seen_m[k] = 1;
         link_age_m[k] = fage + 16'd1;
         routes_stale = 1;
         return pack_rsp(1, fage, s.src, s.dst, s.cost, 0, 0);
      end else if (s.kind == lssp_pkg::KIND_ADV) begin
         if (link_seen_m[k] && link_age_m[k] >= s.age) return '0;
         link_cost_m[k] = s.cost;
         link_seen_m[k] = 1;
         link_age_m[k] = s.age;
         routes_stale = 1;
         return pack_rsp(1, s.age, s.src, s.dst, s.cost, 0, 0);
      end else if (s.kind == lssp_pkg::KIND_QUERY) begin
         if (routes_stale) rebuild_routes();
         if (route_ok_m[s.tgt]) return pack_rsp(0, 0, 0, 0, 0, 1, route_hop_m[s.tgt]);
         return '0;
      end
      return '0;
   endfunction

   function automatic stim_row_type row(logic [1:0] kind, logic [3:0] src, logic [3:0] dst,
                                        logic [15:0] cost, logic [15:0] age, logic [3:0] tgt,
                                        bit typed = 0, rsp_beat_type want = '0);
      stim_row_type s;
      s.kind = kind; s.src = src; s.dst = dst; s.cost = cost; s.age = age; s.tgt = tgt;
      s.typed = typed; s.want = want;
      return s;
   endfunction

   task automatic send_item(stim_row_type s);
      rsp_beat_type p;
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.kind;
      req_tdata  <= {4'b0, s.tgt, s.age, s.cost, s.dst, s.src};
      do @(posedge clock); while (!req_tready);
      // The predictor runs on every beat so that its state tracks the block.
      p = predict_router(s);
      pending_rsp.push_back(s.typed ? s.want : p);
   endtask

   task automatic write_own(logic [3:0] node);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= lssp_pkg::REG_OWN_NODE << 2;
      csr_pwdata <= {28'b0, node};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      own_m = node;
      routes_stale = 1;
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin : rsp_side
      int hold_left;
      rsp_beat_type w;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               $error("result beat with no expectation waiting");
               fails++;
            end else begin
               w = pending_rsp.pop_front();
               check_field("flood_valid", 16'(w.user[0]), 16'(rsp_tuser[0]));
               check_field("flood_age", w.data[15:0], rsp_tdata[15:0]);
               check_field("flood_src", 16'(w.data[19:16]), 16'(rsp_tdata[19:16]));
               check_field("flood_dst", 16'(w.data[23:20]), 16'(rsp_tdata[23:20]));
               check_field("flood_cost", w.data[39:24], rsp_tdata[39:24]);
               check_field("hop_valid", 16'(w.user[1]), 16'(rsp_tuser[1]));
               check_field("next_hop", 16'(w.data[43:40]), 16'(rsp_tdata[43:40]));
            end
         end
         if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stim_side
      stim_row_type dir[$];
      stim_row_type s;
      logic [3:0]   owners [6];
      logic [3:0]   pool [5];
      int           r, k;
      owners = '{4'd15, 4'd3, 4'd0, 4'd7, 4'd12, 4'd1};
      own_m = 0;
      routes_stale = 1;
      for (int i = 0; i < lssp_pkg::LINKS; i++) begin
         link_seen_m[i] = 0;
         link_age_m[i] = 0;
         link_cost_m[i] = 0;
      end
      for (int i = 0; i < lssp_pkg::NODES; i++) route_ok_m[i] = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, unknown kind, saturating path, ties, age wrap and rejections.
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 5, 1, '0));
      dir.push_back(row(KIND_SPARE, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 4'hF, 1, '0));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 0, 1, 40000, 0, 0, 1,
                        pack_rsp(1, 0, 0, 1, 40000, 0, 0)));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 1, 2, 30000, 0, 0, 1,
                        pack_rsp(1, 0, 1, 2, 30000, 0, 0)));
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 2));
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 1));
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 1, '0));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 0, 3, 5, 0, 0));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 0, 4, 5, 0, 0));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 3, 5, 5, 0, 0));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 4, 5, 5, 0, 0));
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 5));
      dir.push_back(row(lssp_pkg::KIND_ADV, 1, 2, 10, 16'hFFFF, 0, 1,
                        pack_rsp(1, 16'hFFFF, 1, 2, 10, 0, 0)));
      dir.push_back(row(lssp_pkg::KIND_ADV, 1, 2, 10, 16'hFFFF, 0, 1, '0));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 1, 2, 0, 0, 0, 1,
                        pack_rsp(1, 16'hFFFF, 1, 2, 0, 0, 0)));
      dir.push_back(row(lssp_pkg::KIND_ADV, 1, 2, 7, 0, 0, 1, '0));
      dir.push_back(row(lssp_pkg::KIND_ADV, 1, 2, 16'hFFFF, 1, 0, 1,
                        pack_rsp(1, 1, 1, 2, 16'hFFFF, 0, 0)));
      dir.push_back(row(lssp_pkg::KIND_ADV, 15, 15, 16'hFFFF, 16'hFFFF, 0, 1,
                        pack_rsp(1, 16'hFFFF, 15, 15, 16'hFFFF, 0, 0)));
      dir.push_back(row(lssp_pkg::KIND_LOCAL, 15, 14, 0, 0, 0, 1,
                        pack_rsp(1, 0, 15, 14, 0, 0, 0)));
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 15));
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 2));
      dir.push_back(row(lssp_pkg::KIND_QUERY, 0, 0, 0, 0, 3));
      foreach (dir[i]) send_item(dir[i]);

      for (int ph = 0; ph < 6; ph++) begin
         write_own(owners[ph]);
         pool[0] = owners[ph];
         for (int i = 1; i < 5; i++) pool[i] = 4'($urandom_range(15));
         calm = (ph == 2);
         for (int n = 0; n < 180; n++) begin
            if (ph == 3 && n == 20) hold_req = 1;
            r = $urandom_range(99);
            s = row(r < 35 ? lssp_pkg::KIND_LOCAL : r < 60 ? lssp_pkg::KIND_ADV :
                    r < 95 ? lssp_pkg::KIND_QUERY : KIND_SPARE,
                    0, 0, 0, 0, 0);
            s.src = ($urandom_range(99) < 80) ? pool[$urandom_range(4)]
                                              : 4'($urandom_range(15));
            s.dst = ($urandom_range(99) < 80) ? pool[$urandom_range(4)]
                                              : 4'($urandom_range(15));
            s.tgt = ($urandom_range(99) < 70) ? pool[$urandom_range(4)]
                                              : 4'($urandom_range(15));
            r = $urandom_range(99);
            s.cost = r < 70 ? 16'($urandom_range(20, 1)) :
                     r < 80 ? 16'd0 : 16'($urandom_range(65535));
            k = s.src * lssp_pkg::NODES + s.dst;
            if (link_seen_m[k] && $urandom_range(99) < 85)
               s.age = 16'(link_age_m[k] + $urandom_range(2) - 1);
            else
               s.age = 16'($urandom_range(65535));
            send_item(s);
         end
      end
      calm = 0;
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fails == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
